[rtl/core/brb_pkg.sv]
// Shared types and constants for the chunked byte ring buffer.
// Used by brb_lane, brb_merge and byte_ring_buffer_chunked_unit; no dependencies.
package brb_pkg;

  // Byte lanes: one bank per byte position of an eight-byte chunk
  localparam int LANES     = 8;
  localparam int LANE_LOG2 = 3;
  localparam int BYTE_W    = 8;
  localparam int DATA_W    = LANES * BYTE_W;
  localparam int COUNT_W   = 4;
  localparam int FILL_W    = 11;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef logic [LANE_LOG2-1:0]          lane_idx_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [LANES-1:0][BYTE_W-1:0]  lane_bytes_t;

  // Per-lane access strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } lane_req_t;

endpackage

[rtl/core/byte_ring_buffer_chunked_unit.sv]
// Chunked byte ring buffer, top level. Depends on brb_pkg, brb_lane, brb_merge.
// Path to result: bank read into the stage, then merge into the result register.
// A new transaction waits until the last has left the single stage register:
// in_ready stays low while a transaction waits there for its bank read data to
// move into the result register. A stalled result holds that stage and the input.
// Reset: rst_n (synchronous, active low) clears both pointers and all valid
// flags; the byte store is not cleared and needs no clearing pass.
module byte_ring_buffer_chunked_unit
  import brb_pkg::*;
#(
  parameter int DEPTH_LOG2 = 10,
  parameter int MAX_CHUNK  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [COUNT_W-1:0] in_byte_count,
  input  logic [DATA_W-1:0]  in_write_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic [DATA_W-1:0]  out_read_data,
  output logic [FILL_W-1:0]  out_fill_level
);

  localparam int PTR_W    = DEPTH_LOG2 + 1;
  localparam int ROW_BITS = DEPTH_LOG2 - LANE_LOG2;
  localparam int ROW_W    = (ROW_BITS > 0) ? ROW_BITS : 1;
  localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((1 << ROW_BITS) - 1);
  localparam logic [PTR_W-1:0] STORE_SIZE = PTR_W'(1 << DEPTH_LOG2);

  typedef logic [PTR_W-1:0] ptr_t;

  // Pointers and pipeline registers
  ptr_t       rd_ptr_r, rd_ptr_nxt;
  ptr_t       wr_ptr_r, wr_ptr_nxt;
  logic       p1_valid_r;
  logic       p1_ok_r;
  logic       p1_read_r;
  lane_idx_t  p1_start_r;
  count_t     p1_count_r;
  logic              out_valid_r;
  logic              out_accepted_r;
  logic [DATA_W-1:0] out_read_data_r;
  logic [FILL_W-1:0] out_fill_level_r;

  logic       in_fire;
  logic       p1_advance;
  ptr_t       fill;
  ptr_t       space;
  ptr_t       cnt_ext;
  logic       count_ok;
  logic       wr_ok;
  logic       rd_ok;
  logic       item_ok;
  ptr_t       base_ptr;
  lane_idx_t  start_lane;
  logic [ROW_W-1:0] base_row;

  lane_req_t         lane_req   [LANES];
  logic [ROW_W-1:0]  lane_row   [LANES];
  logic [BYTE_W-1:0] lane_wbyte [LANES];
  lane_bytes_t       lane_rbytes;
  logic [DATA_W-1:0] merged_data;

  assign in_ready   = !p1_valid_r;
  assign in_fire    = in_valid && in_ready;
  assign p1_advance = p1_valid_r && (!out_valid_r || out_ready);

  // Space and fill checks
  assign fill     = wr_ptr_r - rd_ptr_r;
  assign space    = STORE_SIZE - fill;
  assign cnt_ext  = PTR_W'(in_byte_count);
  assign count_ok = in_byte_count <= COUNT_W'(MAX_CHUNK);
  assign wr_ok    = count_ok && (cnt_ext <= space);
  assign rd_ok    = count_ok && (cnt_ext <= fill);
  assign item_ok  = (in_command == CMD_READ) ? rd_ok : wr_ok;

  // Chunk start address split into bank and row
  assign base_ptr   = (in_command == CMD_READ) ? rd_ptr_r : wr_ptr_r;
  assign start_lane = base_ptr[LANE_LOG2-1:0];
  assign base_row   = ROW_W'(base_ptr >> LANE_LOG2);

  // Per-lane address, strobes and write byte
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      lane_idx_t off;
      logic      active;
      off    = lane_idx_t'(lane_idx_t'(b) - start_lane);
      active = in_fire && item_ok && (COUNT_W'(off) < in_byte_count);
      lane_req[b].wr_en = active && (in_command == CMD_WRITE);
      lane_req[b].rd_en = active && (in_command == CMD_READ);
      lane_row[b]   = (base_row + ROW_W'(lane_idx_t'(b) < start_lane)) & ROW_MASK;
      lane_wbyte[b] = in_write_data[BYTE_W*off +: BYTE_W];
    end
  end

  // Byte banks
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    brb_lane #(
      .ROW_BITS (ROW_BITS),
      .ROW_W    (ROW_W)
    ) u_lane (
      .clk     (clk),
      .req     (lane_req[g]),
      .row     (lane_row[g]),
      .wr_byte (lane_wbyte[g]),
      .rd_byte (lane_rbytes[g])
    );
  end

  // Merge lanes into the packed result
  brb_merge u_merge (
    .lane_bytes (lane_rbytes),
    .start_lane (p1_start_r),
    .byte_count (p1_count_r),
    .enable     (p1_ok_r && p1_read_r),
    .read_data  (merged_data)
  );

  // Pointer update
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    if (in_fire && item_ok) begin
      if (in_command == CMD_READ) begin
        rd_ptr_nxt = rd_ptr_r + cnt_ext;
      end else begin
        wr_ptr_nxt = wr_ptr_r + cnt_ext;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      if (in_fire) begin
        p1_valid_r <= 1'b1;
      end else if (p1_advance) begin
        p1_valid_r <= 1'b0;
      end
      if (p1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_ok_r    <= item_ok;
      p1_read_r  <= (in_command == CMD_READ);
      p1_start_r <= start_lane;
      p1_count_r <= in_byte_count;
    end
    if (p1_advance) begin
      out_accepted_r   <= p1_ok_r;
      out_read_data_r  <= merged_data;
      out_fill_level_r <= FILL_W'(fill);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_read_data  = out_read_data_r;
  assign out_fill_level = out_fill_level_r;

endmodule

[rtl/core/brb_lane.sv]
// One byte bank of the ring buffer store: single write port, registered read.
// Depends on brb_pkg.
module brb_lane
  import brb_pkg::*;
#(
  parameter int ROW_BITS = 7,
  parameter int ROW_W    = 7
) (
  input  logic              clk,
  input  lane_req_t         req,
  input  logic [ROW_W-1:0]  row,
  input  logic [BYTE_W-1:0] wr_byte,
  output logic [BYTE_W-1:0] rd_byte
);

  localparam int ROWS = 1 << ROW_BITS;

  logic [BYTE_W-1:0] mem [ROWS];
  logic [BYTE_W-1:0] rd_byte_r;

  // Bank write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[row] <= wr_byte;
    end
    if (req.rd_en) begin
      rd_byte_r <= mem[row];
    end
  end

  assign rd_byte = rd_byte_r;

endmodule

[rtl/core/brb_merge.sv]
// Merge stage: rotates the bank outputs into chunk order and zeroes unused bytes.
// Depends on brb_pkg.
module brb_merge
  import brb_pkg::*;
(
  input  lane_bytes_t        lane_bytes,
  input  lane_idx_t          start_lane,
  input  count_t             byte_count,
  input  logic               enable,
  output logic [DATA_W-1:0]  read_data
);

  lane_bytes_t packed_bytes;

  // Byte i of the chunk comes from bank (start + i) mod LANES
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (enable && (COUNT_W'(i) < byte_count)) begin
        packed_bytes[i] = lane_bytes[lane_idx_t'(start_lane + lane_idx_t'(i))];
      end else begin
        packed_bytes[i] = '0;
      end
    end
  end

  assign read_data = packed_bytes;

endmodule
